/* rtl/bwca_pkg.sv */
// shared constants, register codes and stage types for the box window counter
`timescale 1ns / 1ps
package bwca_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 128;
    localparam int MAX_WINDOW = 128;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int DIM_W      = 8;
    localparam int CMP_W      = DIM_W + 1;
    localparam int CSUM_W     = $clog2(MAX_WINDOW - 1);
    localparam int COUNT_W    = 14;
    localparam int CHAIN_LEN  = MAX_WINDOW - 1;
    localparam int LINE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int LINE_AW    = ROW_W + COL_W;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

    localparam logic [DIM_W-1:0] ROWS_RESET = 8'd128;
    localparam logic [DIM_W-1:0] COLS_RESET = 8'd128;
    localparam logic [DIM_W-1:0] WIN_RESET  = 8'd3;
    localparam logic [DIM_W-1:0] WIN_MIN    = 8'd3;

    // pixel as it enters the stores
    typedef struct packed {
        logic             fire;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] back_row;
        logic             marked;
    } a_req_t;

    // pixel in the cycle after it enters the stores, while the column sum is updated
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             marked;
        logic             row0;
        logic             sub_en;
        logic             col_first;
        logic             col_ok;
        logic             row_ok;
        logic             k_ok;
        logic             last;
        logic [ROW_W-1:0] top;
        logic [COL_W-1:0] left;
    } stage_b_t;

    typedef struct packed {
        logic shift;
        logic inject;
    } cell_ctrl_t;

endpackage

/* rtl/bwca_cell.sv */
// one cell of the column sum delay chain
`timescale 1ns / 1ps
module bwca_cell import bwca_pkg::*; (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CSUM_W-1:0] din,
    input  logic [CSUM_W-1:0] nbr,
    output logic [CSUM_W-1:0] value
);

    logic [CSUM_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= ctrl.inject ? din : nbr;
        end
    end

    assign value = value_reg;

endmodule

/* rtl/bwca_chain.sv */
// row of cells giving a window-programmable delay of the column sum stream
`timescale 1ns / 1ps
module bwca_chain import bwca_pkg::*; (
    input  logic              aclk,
    input  logic              shift,
    input  logic [DIM_W-1:0]  win,
    input  logic [CSUM_W-1:0] din,
    output logic [CSUM_W-1:0] dout
);

    logic [CSUM_W-1:0] cell_val [CHAIN_LEN];
    cell_ctrl_t        cell_ctrl [CHAIN_LEN];

    // new sum enters at cell K-2 so it reaches cell 0 after K-1 transactions
    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
        logic [CSUM_W-1:0] nbr;

        assign cell_ctrl[k].shift  = shift;
        assign cell_ctrl[k].inject = (win == DIM_W'(k + 2));

        if (k == CHAIN_LEN - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_val[k + 1];
        end

        bwca_cell u_cell (
            .aclk  (aclk),
            .ctrl  (cell_ctrl[k]),
            .din   (din),
            .nbr   (nbr),
            .value (cell_val[k])
        );
    end

    assign dout = cell_val[0];

endmodule

/* rtl/bwca_colsum.sv */
// pixel line store and per-column vertical sum store with update
`timescale 1ns / 1ps
module bwca_colsum import bwca_pkg::*; (
    input  logic              aclk,
    input  a_req_t            a_req,
    input  logic              b_valid,
    input  stage_b_t          b_stage,
    output logic [CSUM_W-1:0] b_old
);

    logic              line_mem [LINE_DEPTH];
    logic [CSUM_W-1:0] csum_mem [MAX_COLS];

    logic              line_rd_reg;
    logic [CSUM_W-1:0] csum_rd_reg;
    logic              fwd_reg;
    logic [CSUM_W-1:0] last_nv_reg;
    logic [CSUM_W-1:0] nv;

    always_ff @(posedge aclk) begin
        if (a_req.fire) begin
            line_mem[{a_req.row, a_req.col}] <= a_req.marked;
            line_rd_reg <= line_mem[{a_req.back_row, a_req.col}];
            csum_rd_reg <= csum_mem[a_req.col];
            // same column written this cycle, memory read returns the stale sum
            fwd_reg     <= b_valid && (b_stage.col == a_req.col);
        end
        if (b_valid) begin
            csum_mem[b_stage.col] <= nv;
            last_nv_reg           <= nv;
        end
    end

    always_comb begin
        if (b_stage.row0) begin
            b_old = '0;
        end else if (fwd_reg) begin
            b_old = last_nv_reg;
        end else begin
            b_old = csum_rd_reg;
        end
        nv = b_old + CSUM_W'(b_stage.marked) - CSUM_W'(b_stage.sub_en & line_rd_reg);
    end

endmodule

/* rtl/box_window_count_argmax_top.sv */
// top level: box window interior count with first-maximum search over a raster frame
// one pixel per cycle except while a frame's last pixel waits; a result shows on m_valid once the
// frame's last pixel has passed the stage B, stage C and result registers (store read, row sum update, compare)
// a frame's last pixel waits while an earlier frame's last pixel is still in the two stages
// behind the input or its result is still held and not taken
// reset: frame_rows 128, frame_cols 128, window_size 3, pixel position and best cleared
`timescale 1ns / 1ps
module box_window_count_argmax_top import bwca_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_marked,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_best_count,
    output logic [ROW_W-1:0]   m_best_row,
    output logic [COL_W-1:0]   m_best_col,
    output logic               m_no_window,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // configuration
    logic [DIM_W-1:0]     rows_reg, cols_reg, win_reg;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_we, cfg_hit;
    logic [DIM_W-1:0]     rows_eff, cols_eff;

    // pixel position and stage A
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [CMP_W-1:0] row_ext, col_ext, win_ext;
    logic             last_col, last_row, frame_last, a_fire;
    a_req_t           a_req;
    stage_b_t         b_next;

    // stage B
    logic               b_valid_reg;
    stage_b_t           b_reg;
    logic [CSUM_W-1:0]  h_cur, h_prev_reg, chain_out;
    logic [COUNT_W-1:0] run_reg, run_next;

    // stage C and result
    logic               c_valid_reg, c_cmp_reg, c_last_reg;
    logic [ROW_W-1:0]   c_top_reg;
    logic [COL_W-1:0]   c_left_reg;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic [ROW_W-1:0]   best_row_reg, best_row_next;
    logic [COL_W-1:0]   best_col_reg, best_col_next;
    logic               upd;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic               m_none_reg;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_hit = cfg_we && (cfg_idx == REG_FRAME_ROWS || cfg_idx == REG_FRAME_COLS ||
                                cfg_idx == REG_WINDOW_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            win_reg  <= WIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_FRAME_ROWS:  rows_reg <= pwdata[DIM_W-1:0];
                REG_FRAME_COLS:  cols_reg <= pwdata[DIM_W-1:0];
                REG_WINDOW_SIZE: win_reg  <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_ROWS:  prdata = DATA_W'(rows_reg);
            REG_FRAME_COLS:  prdata = DATA_W'(cols_reg);
            REG_WINDOW_SIZE: prdata = DATA_W'(win_reg);
            default:         prdata = '0;
        endcase
    end

    // zero acts as one, oversize acts as the store size
    always_comb begin
        if (rows_reg == '0) begin
            rows_eff = DIM_W'(1);
        end else if (rows_reg > DIM_W'(MAX_ROWS)) begin
            rows_eff = DIM_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_reg;
        end
        if (cols_reg == '0) begin
            cols_eff = DIM_W'(1);
        end else if (cols_reg > DIM_W'(MAX_COLS)) begin
            cols_eff = DIM_W'(MAX_COLS);
        end else begin
            cols_eff = cols_reg;
        end
    end

    // stage A: position flags for the incoming pixel
    assign row_ext    = CMP_W'(row_reg);
    assign col_ext    = CMP_W'(col_reg);
    assign win_ext    = CMP_W'(win_reg);
    assign last_col   = (col_ext + CMP_W'(1)) >= CMP_W'(cols_eff);
    assign last_row   = (row_ext + CMP_W'(1)) >= CMP_W'(rows_eff);
    assign frame_last = last_col && last_row;

    assign s_ready = !frame_last ||
                     (!(b_valid_reg && b_reg.last) && !(c_valid_reg && c_last_reg) &&
                      (!m_valid_reg || m_ready));
    assign a_fire  = s_valid && s_ready;

    always_comb begin
        a_req.fire     = a_fire;
        a_req.row      = row_reg;
        a_req.col      = col_reg;
        a_req.back_row = ROW_W'(row_ext + CMP_W'(2) - win_ext);
        a_req.marked   = s_is_marked;

        b_next.col       = col_reg;
        b_next.marked    = s_is_marked;
        b_next.row0      = (row_reg == '0);
        b_next.sub_en    = (row_ext + CMP_W'(2)) >= win_ext;
        b_next.col_first = (col_reg == '0);
        b_next.col_ok    = (col_ext + CMP_W'(1)) >= win_ext;
        b_next.row_ok    = (row_ext + CMP_W'(1)) >= win_ext;
        b_next.k_ok      = win_reg >= WIN_MIN;
        b_next.last      = frame_last;
        b_next.top       = ROW_W'(row_ext + CMP_W'(1) - win_ext);
        b_next.left      = COL_W'(col_ext + CMP_W'(1) - win_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (a_fire) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // stage B
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_fire;
        end
        if (a_fire) begin
            b_reg <= b_next;
        end
    end

    bwca_colsum u_colsum (
        .aclk    (aclk),
        .a_req   (a_req),
        .b_valid (b_valid_reg),
        .b_stage (b_reg),
        .b_old   (h_cur)
    );

    bwca_chain u_chain (
        .aclk  (aclk),
        .shift (b_valid_reg),
        .win   (win_reg),
        .din   (h_cur),
        .dout  (chain_out)
    );

    // horizontal sum over the K-2 interior columns ending one left of this pixel
    always_comb begin
        if (b_reg.col_first) begin
            run_next = '0;
        end else begin
            run_next = run_reg + COUNT_W'(h_prev_reg) -
                       (b_reg.col_ok ? COUNT_W'(chain_out) : COUNT_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            run_reg    <= run_next;
            h_prev_reg <= h_cur;
        end
    end

    // stage C
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            c_cmp_reg   <= 1'b0;
            c_last_reg  <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
            c_cmp_reg   <= b_reg.row_ok && b_reg.col_ok && b_reg.k_ok;
            c_last_reg  <= b_reg.last;
        end
        if (b_valid_reg) begin
            c_top_reg  <= b_reg.top;
            c_left_reg <= b_reg.left;
        end
    end

    // strictly greater keeps the first maximum in raster order
    assign upd           = c_valid_reg && c_cmp_reg && (run_reg > best_reg);
    assign best_next     = upd ? run_reg    : best_reg;
    assign best_row_next = upd ? c_top_reg  : best_row_reg;
    assign best_col_next = upd ? c_left_reg : best_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit || (c_valid_reg && c_last_reg)) begin
            best_reg     <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end else if (upd) begin
            best_reg     <= best_next;
            best_row_reg <= best_row_next;
            best_col_reg <= best_col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_valid_reg && c_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (c_valid_reg && c_last_reg) begin
            m_count_reg <= best_next;
            m_row_reg   <= best_row_next;
            m_col_reg   <= best_col_next;
            m_none_reg  <= (win_reg > rows_eff) || (win_reg > cols_eff);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_count = m_count_reg;
    assign m_best_row   = m_row_reg;
    assign m_best_col   = m_col_reg;
    assign m_no_window  = m_none_reg;

endmodule
